>>> hdl/dll_pkg.sv
`timescale 1ns / 1ps
// Package for the doubly linked list engine: sizes, opcodes, status codes,
// state machine states, memory write and result structs.
// No dependencies.
package dll_pkg;

   localparam int MAX_NODES = 1024;
   localparam int ID_W      = 11;
   localparam int ADDR_W    = $clog2(MAX_NODES);

   localparam logic [ID_W-1:0] NODE_NONE  = '0;
   localparam logic [ID_W-1:0] FIRST_NODE = ID_W'(1);
   localparam logic [ID_W-1:0] FIRST_FREE = ID_W'(2);
   localparam logic [ID_W-1:0] LAST_NODE  = ID_W'(MAX_NODES);

   typedef enum logic [1:0] {
      OP_INS_BEFORE = 2'd0,
      OP_INS_AFTER  = 2'd1,
      OP_REMOVE     = 2'd2,
      OP_READ       = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK             = 2'd0,
      STAT_ANCHOR_ABSENT  = 2'd1,
      STAT_TABLE_FULL     = 2'd2,
      STAT_REMOVE_ABSENT  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_WRITE,
      S_RESP
   } fsm_state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [ID_W-1:0]   data;
   } link_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic              data;
   } gone_wr_type;

   typedef struct packed {
      link_wr_type prev_wr;
      link_wr_type next_wr;
   } second_wr_type;

   typedef struct packed {
      status_type      status;
      logic [ID_W-1:0] new_node;
      logic [ID_W-1:0] prev_node;
      logic [ID_W-1:0] next_node;
      logic            node_present;
      logic [ID_W-1:0] head_node;
   } result_type;

   function automatic logic [ADDR_W-1:0] id_to_addr(input logic [ID_W-1:0] id);
      logic [ID_W-1:0] dec;
      dec = id - ID_W'(1);
      return dec[ADDR_W-1:0];
   endfunction

endpackage

>>> hdl/doubly_linked_list_engine.sv
`timescale 1ns / 1ps
// One request at a time, accepted in S_IDLE; in S_READ the entry read for node_id is decided on
// and the first writes go to the memories, in S_WRITE the second go to the link memories on their
// single write ports (failed and read-only requests skip it), and S_RESP loads the result once the output is free.
// Reset is synchronous; afterwards node 1 alone is present and is the head, with no clearing
// pass: a fill count and row-0 flags stand in for the cleared memories.
// Depends on dll_pkg.
module doubly_linked_list_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_opcode,
   input  logic [dll_pkg::ID_W-1:0] req_node_id,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [dll_pkg::ID_W-1:0] rsp_new_node,
   output logic [dll_pkg::ID_W-1:0] rsp_prev_node,
   output logic [dll_pkg::ID_W-1:0] rsp_next_node,
   output logic                     rsp_node_present,
   output logic [dll_pkg::ID_W-1:0] rsp_head_node
);
   import dll_pkg::*;

   logic [ID_W-1:0] prev_mem [MAX_NODES];
   logic [ID_W-1:0] next_mem [MAX_NODES];
   logic            gone_mem [MAX_NODES];

   fsm_state_type   state_ff, state_in;
   opcode_type      op_ff;
   logic [ID_W-1:0] id_ff;
   logic [ID_W-1:0] head_ff, head_in;
   logic [ID_W-1:0] free_ff, free_in;
   logic            prev0_ok_ff, next0_ok_ff, gone0_ok_ff;
   logic [ID_W-1:0] prev_rd_ff, next_rd_ff;
   logic            gone_rd_ff;
   second_wr_type   w2_ff, w2_in;
   result_type      res_ff, res_in;
   result_type      rsp_ff;
   logic            rsp_valid_ff;

   link_wr_type     w1_prev, w1_next, prev_wr, next_wr;
   gone_wr_type     w1_gone, gone_wr;
   logic [ADDR_W-1:0] rd_addr, id_addr;
   logic            accept, rsp_load, has_writes;
   logic            id_ok, present, full, is_ins, do_ins, do_rem;
   logic [ID_W-1:0] p_val, s_val, fresh;

   assign rd_addr = id_to_addr(req_node_id);
   assign id_addr = id_to_addr(id_ff);
   assign accept  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (prev_wr.en) prev_mem[prev_wr.addr] <= prev_wr.data;
      prev_rd_ff <= prev_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (next_wr.en) next_mem[next_wr.addr] <= next_wr.data;
      next_rd_ff <= next_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (gone_wr.en) gone_mem[gone_wr.addr] <= gone_wr.data;
      gone_rd_ff <= gone_mem[rd_addr];
   end

   // Decide the operation from the entry read for node_id.
   always_comb begin
      id_ok   = (id_ff != NODE_NONE) && (id_ff <= LAST_NODE);
      p_val   = (id_addr == '0 && !prev0_ok_ff) ? NODE_NONE : prev_rd_ff;
      s_val   = (id_addr == '0 && !next0_ok_ff) ? NODE_NONE : next_rd_ff;
      present = id_ok && (id_ff < free_ff)
                && !(gone_rd_ff && (id_addr != '0 || gone0_ok_ff));
      full    = free_ff > LAST_NODE;
      is_ins  = (op_ff == OP_INS_BEFORE) || (op_ff == OP_INS_AFTER);
      do_ins  = is_ins && present && !full;
      do_rem  = (op_ff == OP_REMOVE) && present;
      fresh   = free_ff;

      w1_prev = '0;
      w1_next = '0;
      w1_gone = '0;
      w2_in   = '0;
      head_in = head_ff;
      free_in = free_ff;

      res_in.status       = STAT_OK;
      res_in.new_node     = NODE_NONE;
      res_in.prev_node    = present ? p_val : NODE_NONE;
      res_in.next_node    = present ? s_val : NODE_NONE;
      res_in.node_present = present;

      if (is_ins && !present) begin
         res_in.status = STAT_ANCHOR_ABSENT;
      end else if (is_ins && full) begin
         res_in.status = STAT_TABLE_FULL;
      end else if (op_ff == OP_REMOVE && !present) begin
         res_in.status = STAT_REMOVE_ABSENT;
      end

      if (do_ins) begin
         free_in         = free_ff + ID_W'(1);
         res_in.new_node = fresh;
         w1_gone         = '{en: 1'b1, addr: id_to_addr(fresh), data: 1'b0};
         if (op_ff == OP_INS_BEFORE) begin
            w1_prev          = '{en: 1'b1, addr: id_to_addr(fresh), data: p_val};
            w1_next          = '{en: 1'b1, addr: id_to_addr(fresh), data: id_ff};
            w2_in.prev_wr    = '{en: 1'b1, addr: id_addr, data: fresh};
            w2_in.next_wr    = '{en: (p_val != NODE_NONE), addr: id_to_addr(p_val),
                                 data: fresh};
            if (p_val == NODE_NONE) head_in = fresh;
            res_in.prev_node = fresh;
         end else begin
            w1_prev          = '{en: 1'b1, addr: id_to_addr(fresh), data: id_ff};
            w1_next          = '{en: 1'b1, addr: id_to_addr(fresh), data: s_val};
            w2_in.next_wr    = '{en: 1'b1, addr: id_addr, data: fresh};
            w2_in.prev_wr    = '{en: (s_val != NODE_NONE), addr: id_to_addr(s_val),
                                 data: fresh};
            res_in.next_node = fresh;
         end
      end else if (do_rem) begin
         w1_next = '{en: (p_val != NODE_NONE), addr: id_to_addr(p_val), data: s_val};
         w1_prev = '{en: (s_val != NODE_NONE), addr: id_to_addr(s_val), data: p_val};
         w1_gone = '{en: 1'b1, addr: id_addr, data: 1'b1};
         w2_in.prev_wr = '{en: 1'b1, addr: id_addr, data: NODE_NONE};
         w2_in.next_wr = '{en: 1'b1, addr: id_addr, data: NODE_NONE};
         if (head_ff == id_ff) head_in = s_val;
         res_in.prev_node    = NODE_NONE;
         res_in.next_node    = NODE_NONE;
         res_in.node_present = 1'b0;
      end

      res_in.head_node = head_in;
      has_writes       = do_ins || do_rem;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_READ;
         S_READ:  state_in = has_writes ? S_WRITE : S_RESP;
         S_WRITE: state_in = S_RESP;
         S_RESP:  if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      prev_wr   = '0;
      next_wr   = '0;
      gone_wr   = '0;
      unique case (state_ff)
         S_IDLE:  req_ready = 1'b1;
         S_READ: begin
            prev_wr = w1_prev;
            next_wr = w1_next;
            gone_wr = w1_gone;
         end
         S_WRITE: begin
            prev_wr = w2_ff.prev_wr;
            next_wr = w2_ff.next_wr;
         end
         S_RESP:  rsp_load = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= FIRST_NODE;
         free_ff      <= FIRST_FREE;
         prev0_ok_ff  <= 1'b0;
         next0_ok_ff  <= 1'b0;
         gone0_ok_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_READ) begin
            head_ff <= head_in;
            free_ff <= free_in;
         end
         if (prev_wr.en && prev_wr.addr == '0) prev0_ok_ff <= 1'b1;
         if (next_wr.en && next_wr.addr == '0) next0_ok_ff <= 1'b1;
         if (gone_wr.en && gone_wr.addr == '0) gone0_ok_ff <= 1'b1;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= opcode_type'(req_opcode);
         id_ff <= req_node_id;
      end
      if (state_ff == S_READ) begin
         w2_ff  <= w2_in;
         res_ff <= res_in;
      end
      if (rsp_load) rsp_ff <= res_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_new_node     = rsp_ff.new_node;
   assign rsp_prev_node    = rsp_ff.prev_node;
   assign rsp_next_node    = rsp_ff.next_node;
   assign rsp_node_present = rsp_ff.node_present;
   assign rsp_head_node    = rsp_ff.head_node;

endmodule

>>> hdl/dll_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the doubly linked list engine, bound to its top level.
// Depends on dll_pkg and doubly_linked_list_engine.
module dll_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [1:0]               req_opcode,
   input logic [dll_pkg::ID_W-1:0] req_node_id,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [1:0]               rsp_status,
   input logic [dll_pkg::ID_W-1:0] rsp_new_node,
   input logic [dll_pkg::ID_W-1:0] rsp_prev_node,
   input logic [dll_pkg::ID_W-1:0] rsp_next_node,
   input logic                     rsp_node_present,
   input logic [dll_pkg::ID_W-1:0] rsp_head_node
);
   import dll_pkg::*;

   // A stalled result beat holds its status, new node and head node.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                 && $stable(rsp_new_node) && $stable(rsp_head_node))
      else $error("result beat changed while stalled");

   // Requests are handled one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // Only a successful insert hands out a new id, and its anchor node is reported present.
   a_new_node: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_node != NODE_NONE |-> rsp_status == STAT_OK && rsp_node_present)
      else $error("new id reported without a successful insert");

   // An absent node never exposes links.
   a_absent_links: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_node_present |-> rsp_prev_node == NODE_NONE
                                          && rsp_next_node == NODE_NONE)
      else $error("absent node reported with links");

endmodule

bind doubly_linked_list_engine dll_checker u_dll_checker (.*);
